FILE: hw/rtl/pps_pkg.sv
`default_nettype none

package pps_pkg;

  // debounce thresholds
  localparam logic [3:0] POWER_SET_COUNT   = 4'd10;
  localparam logic [3:0] POWER_CLEAR_COUNT = 4'd5;
  localparam logic [2:0] HEAT_COUNT        = 3'd5;
  localparam logic signed [8:0] HEAT_HYSTERESIS = 9'sd10;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_MIN_SUPPLY = 2'd0,
    REG_MAX_SUPPLY = 2'd1,
    REG_TEMP_LIMIT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    SUPPLY_OK    = 2'd0,
    SUPPLY_OVER  = 2'd1,
    SUPPLY_UNDER = 2'd2
  } supply_status_t;

  typedef struct packed {
    logic [11:0]        min_supply;
    logic [11:0]        max_supply;
    logic signed [7:0]  temp_limit;
  } cfg_regs_t;

  // packed from msb down, so supply_volts sits in the low bits
  typedef struct packed {
    logic               system_closing;
    logic               discharge_allowed;
    logic               port_on;
    logic               port_active;
    logic signed [7:0]  port_temp;
    logic [11:0]        supply_volts;
  } sample_t;

  typedef struct packed {
    supply_status_t     supply_status;
    logic               off_request;
    logic               fault_changed;
    logic               heat_fault;
    logic               power_fault;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/port_protection_supervisor.sv
// port protection supervisor
// in_*  : one check sample per word; in_tdata holds supply_volts, port_temp,
//         port_active, port_on, discharge_allowed, system_closing
// out_* : one result word per sample, in order; out_tdata holds power_fault,
//         heat_fault, fault_changed, off_request, supply_status
// cfg_* : register port for min_supply (0x0), max_supply (0x4) and
//         temp_limit (0x8); write only while no sample is in flight
// latency: a sample taken at one edge is registered, checked against the
//          debounce state at the next edge and shown on out_tvalid from then,
//          two cycles in all
// throughput: one sample per cycle; the debounce state updates in the same
//          cycle a sample moves into the output register, so the next sample
//          sees it at once
// stall: while out_tready is low the result holds and one more sample can
//        wait in the input register; in_tready drops only when both are full
// reset: rst_n (synchronous, active low) empties both registers, clears the
//        debounce counters and fault flags and loads the register defaults
`default_nettype none

module port_protection_supervisor (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // supply_volts[11:0], port_temp[19:12], port_active[20], port_on[21],
  // discharge_allowed[22], system_closing[23]
  input  wire logic [23:0]                    in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // power_fault[0], heat_fault[1], fault_changed[2], off_request[3],
  // supply_status[5:4], zeros[7:6]
  output logic [7:0]                          out_tdata,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [pps_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [pps_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [pps_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                cfg_pready
);
  import pps_pkg::*;

  cfg_regs_t cfg_regs;
  sample_t   smp_r;
  logic      smp_valid_r, smp_valid_nxt;
  result_t   res;
  result_t   res_r;
  logic      res_valid_r, res_valid_nxt;
  logic      step;
  logic      in_fire;

  pps_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_regs    (cfg_regs)
  );

  pps_check u_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .sample (smp_r),
    .cfg    (cfg_regs),
    .result (res)
  );

  // sample moves to the output register when that is empty or being drained
  assign step      = smp_valid_r && (!res_valid_r || out_tready);
  assign in_tready = !smp_valid_r || step;
  assign in_fire   = in_tvalid && in_tready;

  assign smp_valid_nxt = in_fire || (smp_valid_r && !step);
  assign res_valid_nxt = step || (res_valid_r && !out_tready);

  assign out_tvalid = res_valid_r;
  assign out_tdata  = {2'b00, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      smp_valid_r <= smp_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      smp_r <= sample_t'(in_tdata);
    end
    if (step) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pps_cfg.sv
`default_nettype none

module pps_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [pps_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [pps_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [pps_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                  cfg_pready,
  output pps_pkg::cfg_regs_t                    cfg_regs
);
  import pps_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;
  logic      wr_en;
  reg_idx_t  idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_regs   = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (idx)
        REG_MIN_SUPPLY: regs_nxt.min_supply = cfg_pwdata[11:0];
        REG_MAX_SUPPLY: regs_nxt.max_supply = cfg_pwdata[11:0];
        REG_TEMP_LIMIT: regs_nxt.temp_limit = cfg_pwdata[7:0];
        default: regs_nxt = regs_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_SUPPLY: cfg_prdata = {20'd0, regs_r.min_supply};
      REG_MAX_SUPPLY: cfg_prdata = {20'd0, regs_r.max_supply};
      REG_TEMP_LIMIT: cfg_prdata = {24'd0, regs_r.temp_limit};
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.min_supply <= 12'd45;
      regs_r.max_supply <= 12'd250;
      regs_r.temp_limit <= 8'sd60;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pps_check.sv
`default_nettype none

module pps_check (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  pps_pkg::sample_t   sample,
  input  pps_pkg::cfg_regs_t cfg,
  output pps_pkg::result_t   result
);
  import pps_pkg::*;

  logic [3:0] power_count_r, power_count_nxt;
  logic [2:0] heat_count_r, heat_count_nxt;
  logic       power_flag_r, power_flag_nxt;
  logic       heat_flag_r, heat_flag_nxt;

  supply_status_t   status;
  logic             bad;
  logic [3:0]       power_inc;
  logic [3:0]       power_need;
  logic [2:0]       heat_inc;
  logic signed [8:0] temp_x;
  logic signed [8:0] limit_x;
  logic signed [8:0] low_level;
  logic             hot;
  logic             cool;

  always_comb begin
    if (sample.supply_volts >= cfg.min_supply && sample.supply_volts <= cfg.max_supply) begin
      status = SUPPLY_OK;
    end else if (sample.supply_volts > cfg.max_supply) begin
      status = SUPPLY_OVER;
    end else begin
      status = SUPPLY_UNDER;
    end
  end

  assign bad        = (status != SUPPLY_OK);
  assign power_inc  = power_count_r + 4'd1;
  assign power_need = power_flag_r ? POWER_CLEAR_COUNT : POWER_SET_COUNT;
  assign heat_inc   = heat_count_r + 3'd1;
  assign temp_x     = {sample.port_temp[7], sample.port_temp};
  assign limit_x    = {cfg.temp_limit[7], cfg.temp_limit};
  assign low_level  = limit_x - HEAT_HYSTERESIS;
  assign hot        = temp_x > limit_x;
  assign cool       = temp_x < low_level;

  always_comb begin
    power_count_nxt = power_count_r;
    power_flag_nxt  = power_flag_r;
    heat_count_nxt  = heat_count_r;
    heat_flag_nxt   = heat_flag_r;
    if (sample.port_active) begin
      if (bad != power_flag_r) begin
        if (power_inc >= power_need) begin
          power_count_nxt = 4'd0;
          power_flag_nxt  = bad;
        end else begin
          power_count_nxt = power_inc;
        end
      end else begin
        power_count_nxt = 4'd0;
      end

      // between the two levels the heat count holds
      if (hot || cool) begin
        if (hot != heat_flag_r) begin
          if (heat_inc >= HEAT_COUNT) begin
            heat_count_nxt = 3'd0;
            heat_flag_nxt  = hot;
          end else begin
            heat_count_nxt = heat_inc;
          end
        end else begin
          heat_count_nxt = 3'd0;
        end
      end
    end
  end

  always_comb begin
    result.power_fault   = power_flag_nxt;
    result.heat_fault    = heat_flag_nxt;
    result.fault_changed = (power_flag_nxt != power_flag_r) || (heat_flag_nxt != heat_flag_r);
    result.off_request   = sample.port_on && (!sample.discharge_allowed || sample.system_closing);
    result.supply_status = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_count_r <= 4'd0;
      heat_count_r  <= 3'd0;
      power_flag_r  <= 1'b0;
      heat_flag_r   <= 1'b0;
    end else if (step) begin
      power_count_r <= power_count_nxt;
      heat_count_r  <= heat_count_nxt;
      power_flag_r  <= power_flag_nxt;
      heat_flag_r   <= heat_flag_nxt;
    end
  end

endmodule

`default_nettype wire
